/* rtl/core/drat_pkg.sv */
// Shared constants, codes and types of the DRAM RFM activation tracker.
// Used by the tracker core, its saturating count unit and its port checker.
package drat_pkg;

   // Geometry
   localparam int NUM_RANKS       = 2;
   localparam int NUM_BANK_GROUPS = 8;
   localparam int BANKS_PER_GROUP = 4;
   localparam int BANKS_PER_RANK  = NUM_BANK_GROUPS * BANKS_PER_GROUP;
   localparam int TOTAL_BANKS     = NUM_RANKS * BANKS_PER_RANK;
   localparam int IDX_W           = (TOTAL_BANKS > 1) ? $clog2(TOTAL_BANKS) : 1;
   localparam int STEP_W          = $clog2(BANKS_PER_RANK + 1);

   // Field and register widths
   localparam int CNT_W    = 13;
   localparam int LIMIT_W  = CNT_W + 1;
   localparam int THR_W    = 10;
   localparam int PP_W     = 3;
   localparam int KIND_W   = 2;
   localparam int PERIOD_W = 8;
   localparam int CMD_W    = 2;
   localparam int RANK_W   = 1;
   localparam int GROUP_W  = 3;
   localparam int BANK_W   = 2;
   localparam int TDATA_W  = 8;

   localparam logic [CNT_W-1:0] CNT_MAX = '1;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_OTHER = 2'd0;
   localparam logic [CMD_W-1:0] CMD_ACT   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_REFAB = 2'd2;

   // RFM kinds
   localparam logic [KIND_W-1:0] KIND_ALL  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_SAME = 2'd1;
   localparam logic [KIND_W-1:0] KIND_PER  = 2'd2;

   // Configuration register indexes
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 10;
   localparam logic [CSR_ADDR_W-1:0] CSR_THRESHOLD = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_POSTPONE  = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_KIND      = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_PERIOD    = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_EARLY     = 3'd4;

   // Reset values
   localparam logic [THR_W-1:0]    RST_THRESHOLD = 10'd75;
   localparam logic [PP_W-1:0]     RST_POSTPONE  = 3'd2;
   localparam logic [KIND_W-1:0]   RST_KIND      = KIND_SAME;
   localparam logic [PERIOD_W-1:0] RST_PERIOD    = 8'd1;
   localparam logic                RST_EARLY     = 1'b1;

   // Control of the shared count unit
   typedef struct packed {
      logic             inc;     // 1: saturating +1, 0: floored subtract
      logic [THR_W-1:0] amount;
   } drat_alu_ctl_type;

endpackage

/* rtl/core/drat_alu.sv */
// Shared saturating count unit of the RFM activation tracker.
// Depends on drat_pkg for widths and the control struct.
module drat_alu
   import drat_pkg::*;
(
   input  drat_alu_ctl_type   ctl,
   input  logic [CNT_W-1:0]   value,
   output logic [CNT_W-1:0]   result
);

   logic [CNT_W-1:0] amount_ext;

   assign amount_ext = CNT_W'(ctl.amount);

   always_comb begin
      if (ctl.inc) begin
         result = (value == CNT_MAX) ? value : value + 1'b1;
      end else if (value >= amount_ext) begin
         result = value - amount_ext;
      end else begin
         result = '0;
      end
   end

endmodule

/* rtl/core/dram_rfm_activation_tracker_core.sv */
// DRAM RFM activation tracker: per-bank rolling activation counts in a local
// memory, per-rank refresh counts, and a sequencer around drat_alu.
// Depends on drat_pkg and drat_alu.
//
// Usage:
//   req_* carries one issued DRAM command (other, activate, all-bank refresh).
//   rsp_* carries an RFM request when an activate drives its bank count to
//   (max_postponement+1)*activation_threshold. The user must let csr_* write
//   configuration registers only while the block is idle; it has no check.
// Sequence:
//   An activate is accepted, reads its count and updates it. When an RFM fires,
//   the response is loaded, then each serviced bank is read, subtracted and
//   written back through the one count unit and the single memory port:
//   1 bank, NUM_BANK_GROUPS banks or BANKS_PER_RANK banks. An all-bank refresh
//   that credits its rank walks its BANKS_PER_RANK banks the same way; other
//   commands finish on acceptance. req_tready is low while busy.
// Reset:
//   Synchronous reset clears the valid bits of the count memory (every count
//   reads zero), the refresh counts and restores the register defaults.
// Stall:
//   A result waits in the output register; the block keeps taking requests
//   and only holds in the response-load step while that register is full and not being taken.
module dram_rfm_activation_tracker_core
   import drat_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // command[1:0], rank[2], bank_group[5:3], bank[7:6]
   input  logic [TDATA_W-1:0]     req_tdata,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // rfm_kind[1:0], rfm_rank[2], rfm_bank_group[5:3], rfm_bank[7:6]
   output logic [TDATA_W-1:0]     rsp_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic                   csr_we,
   input  logic [CSR_ADDR_W-1:0]  csr_addr,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_ACT_RD  = 3'd1;
   localparam logic [2:0] S_ACT_UPD = 3'd2;
   localparam logic [2:0] S_EMIT    = 3'd3;
   localparam logic [2:0] S_WALK_RD = 3'd4;
   localparam logic [2:0] S_WALK_WR = 3'd5;

   localparam logic [1:0] WALK_RANK = 2'd0;
   localparam logic [1:0] WALK_BANK = 2'd1;
   localparam logic [1:0] WALK_ONE  = 2'd2;

   // Configuration
   logic [THR_W-1:0]    thr_ff;
   logic [PP_W-1:0]     pp_ff;
   logic [KIND_W-1:0]   kind_sel_ff;
   logic [PERIOD_W-1:0] period_ff;
   logic                early_ff;
   logic [LIMIT_W-1:0]  limit_ff, limit_in;
   logic [KIND_W-1:0]   kind_eff;

   // Sequencer
   logic [2:0]          state_ff, state_in;
   logic [1:0]          walk_mode_ff, walk_mode_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [STEP_W-1:0]   walk_len_ff, walk_len_in;
   logic [RANK_W-1:0]   rank_ff, rank_in;
   logic [GROUP_W-1:0]  group_ff, group_in;
   logic [BANK_W-1:0]   bank_ff, bank_in;
   logic [IDX_W-1:0]    act_id_ff, act_id_in;
   logic [PERIOD_W-1:0] ref_cnt_ff [NUM_RANKS];
   logic [PERIOD_W-1:0] ref_cnt_in [NUM_RANKS];

   // Response register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [TDATA_W-1:0]  rsp_data_ff, rsp_data_in;

   // Count memory
   logic [CNT_W-1:0]       cnt_mem [TOTAL_BANKS];
   logic [TOTAL_BANKS-1:0] valid_ff;
   logic [CNT_W-1:0]       rd_data_ff;
   logic                   rd_valid_ff;
   logic [IDX_W-1:0]       mem_addr;
   logic [IDX_W-1:0]       walk_id;
   logic [IDX_W-1:0]       walk_base;
   logic                   wr_en;

   // Shared unit
   drat_alu_ctl_type    alu_ctl;
   logic [CNT_W-1:0]    alu_value;
   logic [CNT_W-1:0]    alu_result;

   // Request decode
   logic [CMD_W-1:0]    req_cmd;
   logic [RANK_W-1:0]   req_rank;
   logic [GROUP_W-1:0]  req_group;
   logic [BANK_W-1:0]   req_bank;
   logic [PERIOD_W-1:0] ref_next;
   logic                req_fire;
   logic                rsp_free;
   logic                walk_last;
   logic [KIND_W-1:0]   rsp_kind;

   assign req_cmd   = req_tdata[1:0];
   assign req_rank  = req_tdata[2];
   assign req_group = req_tdata[5:3];
   assign req_bank  = req_tdata[7:6];

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   assign kind_eff = (kind_sel_ff > KIND_PER) ? KIND_PER : kind_sel_ff;
   assign limit_in = LIMIT_W'(PP_W'(pp_ff) + (PP_W+1)'(1)) * LIMIT_W'(thr_ff);
   assign ref_next = ref_cnt_ff[req_rank] + 1'b1;
   assign act_id_in = IDX_W'(int'(req_rank) * BANKS_PER_RANK
                            + int'(req_group) * BANKS_PER_GROUP + int'(req_bank));

   // Bank address of the current credit walk step
   assign walk_base = IDX_W'(int'(rank_ff) * BANKS_PER_RANK);
   always_comb begin
      unique case (walk_mode_ff)
         WALK_RANK: walk_id = walk_base + IDX_W'(step_ff);
         WALK_BANK: walk_id = walk_base + IDX_W'(int'(step_ff) * BANKS_PER_GROUP)
                              + IDX_W'(bank_ff);
         default:   walk_id = act_id_ff;
      endcase
   end

   assign walk_last = (STEP_W'(step_ff + 1'b1) == walk_len_ff);
   assign mem_addr  = (state_ff == S_ACT_RD || state_ff == S_ACT_UPD) ? act_id_ff : walk_id;
   assign wr_en     = (state_ff == S_ACT_UPD) || (state_ff == S_WALK_WR);

   assign alu_ctl.inc    = (state_ff == S_ACT_UPD);
   assign alu_ctl.amount = thr_ff;
   assign alu_value      = rd_valid_ff ? rd_data_ff : '0;

   drat_alu u_alu (
      .ctl    (alu_ctl),
      .value  (alu_value),
      .result (alu_result)
   );

   assign rsp_kind = kind_eff;

   always_comb begin
      state_in     = state_ff;
      walk_mode_in = walk_mode_ff;
      step_in      = step_ff;
      walk_len_in  = walk_len_ff;
      rank_in      = rank_ff;
      group_in     = group_ff;
      bank_in      = bank_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      for (int r = 0; r < NUM_RANKS; r++) begin
         ref_cnt_in[r] = ref_cnt_ff[r];
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               rank_in  = req_rank;
               group_in = req_group;
               bank_in  = req_bank;
               // drop commands to ranks, groups or banks that do not exist
               if (int'(req_rank) < NUM_RANKS) begin
                  if (req_cmd == CMD_REFAB && period_ff != '0) begin
                     if (ref_next >= period_ff || ref_next == '0) begin
                        ref_cnt_in[req_rank] = '0;
                        walk_mode_in = WALK_RANK;
                        walk_len_in  = STEP_W'(BANKS_PER_RANK);
                        step_in      = '0;
                        state_in     = S_WALK_RD;
                     end else begin
                        ref_cnt_in[req_rank] = ref_next;
                     end
                  end else if (req_cmd == CMD_ACT
                               && int'(req_group) < NUM_BANK_GROUPS
                               && int'(req_bank) < BANKS_PER_GROUP) begin
                     state_in = S_ACT_RD;
                  end
               end
            end
         end
         S_ACT_RD: begin
            state_in = S_ACT_UPD;
         end
         S_ACT_UPD: begin
            if (LIMIT_W'(alu_result) >= limit_ff) begin
               step_in  = '0;
               state_in = S_EMIT;
               if (kind_eff == KIND_ALL && early_ff) begin
                  walk_mode_in = WALK_RANK;
                  walk_len_in  = STEP_W'(BANKS_PER_RANK);
               end else if (kind_eff == KIND_SAME && early_ff) begin
                  walk_mode_in = WALK_BANK;
                  walk_len_in  = STEP_W'(NUM_BANK_GROUPS);
               end else begin
                  walk_mode_in = WALK_ONE;
                  walk_len_in  = STEP_W'(1);
               end
            end else begin
               state_in = S_IDLE;
            end
         end
         S_EMIT: begin
            // hold until the output register is free
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {(rsp_kind == KIND_ALL) ? BANK_W'(0) : bank_ff,
                               (rsp_kind == KIND_PER) ? group_ff : GROUP_W'(0),
                               rank_ff, rsp_kind};
               state_in     = S_WALK_RD;
            end
         end
         S_WALK_RD: begin
            state_in = S_WALK_WR;
         end
         S_WALK_WR: begin
            if (walk_last) begin
               state_in = S_IDLE;
            end else begin
               step_in  = STEP_W'(step_ff + 1'b1);
               state_in = S_WALK_RD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         valid_ff     <= '0;
         thr_ff       <= RST_THRESHOLD;
         pp_ff        <= RST_POSTPONE;
         kind_sel_ff  <= RST_KIND;
         period_ff    <= RST_PERIOD;
         early_ff     <= RST_EARLY;
         for (int r = 0; r < NUM_RANKS; r++) begin
            ref_cnt_ff[r] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (wr_en) begin
            valid_ff[mem_addr] <= 1'b1;
         end
         for (int r = 0; r < NUM_RANKS; r++) begin
            ref_cnt_ff[r] <= ref_cnt_in[r];
         end
         if (csr_we) begin
            unique case (csr_addr)
               CSR_THRESHOLD: thr_ff      <= csr_wdata[THR_W-1:0];
               CSR_POSTPONE:  pp_ff       <= csr_wdata[PP_W-1:0];
               CSR_KIND:      kind_sel_ff <= csr_wdata[KIND_W-1:0];
               CSR_PERIOD:    period_ff   <= csr_wdata[PERIOD_W-1:0];
               CSR_EARLY:     early_ff    <= csr_wdata[0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      limit_ff    <= limit_in;
      walk_mode_ff <= walk_mode_in;
      step_ff     <= step_in;
      walk_len_ff <= walk_len_in;
      rank_ff     <= rank_in;
      group_ff    <= group_in;
      bank_ff     <= bank_in;
      rsp_data_ff <= rsp_data_in;
      if (req_fire) begin
         act_id_ff <= act_id_in;
      end
   end

   // Count memory: one address per cycle shared by the read and the write, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         cnt_mem[mem_addr] <= alu_result;
      end
      rd_data_ff  <= cnt_mem[mem_addr];
      rd_valid_ff <= valid_ff[mem_addr];
   end

endmodule

/* rtl/core/drat_checker.sv */
// Port-level checker for the DRAM RFM activation tracker core and its bind.
// Depends on drat_pkg for field codes and widths.
module drat_checker
   import drat_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_tready,
   input logic [TDATA_W-1:0] rsp_tdata,
   input logic               rsp_tvalid,
   input logic               rsp_tready
);

   // stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   // kind select 3 reports as per-bank
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[1:0] != 2'd3)
      else $error("unused RFM kind on response");

   // group only for per-bank, bank not for all-bank
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[1:0] == KIND_PER || rsp_tdata[5:3] == 3'd0)
                  && (rsp_tdata[1:0] != KIND_ALL || rsp_tdata[7:6] == 2'd0))
      else $error("response address fields not cleared");

   // a new response is loaded only while a request is in progress
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !$past(req_tready))
      else $error("response appeared while idle");

endmodule

bind dram_rfm_activation_tracker_core drat_checker u_drat_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);
